// ----- rtl/cth_pkg.sv -----
`timescale 1ns / 1ps

package cth_pkg;

    // Field widths
    localparam int BTN_W     = 2;
    localparam int ELAPSED_W = 16;
    localparam int CMD_W     = 3;
    localparam int CODE_W    = 3;
    localparam int HOUR_W    = 5;
    localparam int UNIT_W    = 6;
    localparam int MS_W      = 10;
    localparam int SEC_Q_W   = 7;
    localparam int SOUND_W   = 2;
    localparam int DUR_W     = 27;

    // Time constants
    localparam logic [DUR_W-1:0]  MS_MAX   = 27'd86400000;
    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd24;
    localparam logic [UNIT_W-1:0] UNIT_MAX = 6'd59;
    localparam logic [DUR_W-1:0]  START_DURATION_RST = 27'd60000;

    // elapsed / 1000 = ((elapsed >> 3) * SEC_RECIP) >> SEC_SHIFT, exact over 16 bits
    localparam logic [13:0] SEC_RECIP = 14'd8389;
    localparam int          SEC_SHIFT = 20;
    localparam logic [16:0] MS_PER_SEC = 17'd1000;

    // Button events
    localparam logic [BTN_W-1:0] BTN_PRESS = 2'd1;
    localparam logic [BTN_W-1:0] BTN_HOLD  = 2'd2;

    // Adjust commands
    localparam logic [CMD_W-1:0] ADJ_HOUR_UP   = 3'd1;
    localparam logic [CMD_W-1:0] ADJ_HOUR_DOWN = 3'd2;
    localparam logic [CMD_W-1:0] ADJ_MIN_UP    = 3'd3;
    localparam logic [CMD_W-1:0] ADJ_MIN_DOWN  = 3'd4;
    localparam logic [CMD_W-1:0] ADJ_SEC_UP    = 3'd5;
    localparam logic [CMD_W-1:0] ADJ_SEC_DOWN  = 3'd6;

    // Reported mode codes
    localparam logic [CODE_W-1:0] CODE_PAUSED   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_RUNNING  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SET_SEC  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SET_MIN  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_SET_HOUR = 3'd4;

    // Buzzer codes
    localparam logic [SOUND_W-1:0] SOUND_NONE  = 2'd0;
    localparam logic [SOUND_W-1:0] SOUND_BEEP  = 2'd1;
    localparam logic [SOUND_W-1:0] SOUND_ALARM = 2'd2;

    typedef enum logic [4:0] {
        MODE_PAUSED   = 5'b00001,
        MODE_RUNNING  = 5'b00010,
        MODE_SET_SEC  = 5'b00100,
        MODE_SET_MIN  = 5'b01000,
        MODE_SET_HOUR = 5'b10000
    } mode_t;

    // Remaining time held in mixed radix
    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [UNIT_W-1:0] minutes;
        logic [UNIT_W-1:0] seconds;
        logic [MS_W-1:0]   millis;
    } hms_t;

    localparam hms_t START_TIME_RST = '{hours: 5'd0, minutes: 6'd1, seconds: 6'd0,
                                        millis: 10'd0};

    // One item after the elapsed time is split into seconds and milliseconds
    typedef struct packed {
        logic [BTN_W-1:0]   button;
        logic [CMD_W-1:0]   cmd;
        logic [SEC_Q_W-1:0] el_sec;
        logic [MS_W-1:0]    el_ms;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  timer_mode;
        logic [HOUR_W-1:0]  hours;
        logic [UNIT_W-1:0]  minutes;
        logic [UNIT_W-1:0]  seconds;
        logic               times_up;
        logic [SOUND_W-1:0] sound;
    } result_t;

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_RUNNING:  c = CODE_RUNNING;
            MODE_SET_SEC:  c = CODE_SET_SEC;
            MODE_SET_MIN:  c = CODE_SET_MIN;
            MODE_SET_HOUR: c = CODE_SET_HOUR;
            default:       c = CODE_PAUSED;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/cth_if.sv -----
`timescale 1ns / 1ps

interface cth_item_if;
    logic                             valid;
    logic                             ready;
    logic [cth_pkg::BTN_W-1:0]        button_event;
    logic [cth_pkg::ELAPSED_W-1:0]    elapsed_ms;
    logic [cth_pkg::CMD_W-1:0]        mode;

    modport source (output valid, button_event, elapsed_ms, mode, input ready);
    modport sink   (input valid, button_event, elapsed_ms, mode, output ready);
endinterface

interface cth_result_if;
    logic                             valid;
    logic                             ready;
    logic [cth_pkg::CODE_W-1:0]       timer_mode;
    logic [cth_pkg::HOUR_W-1:0]       hours_left;
    logic [cth_pkg::UNIT_W-1:0]       minutes_left;
    logic [cth_pkg::UNIT_W-1:0]       seconds_left;
    logic                             times_up;
    logic [cth_pkg::SOUND_W-1:0]      sound;

    modport source (output valid, timer_mode, hours_left, minutes_left, seconds_left,
                    times_up, sound, input ready);
    modport sink   (input valid, timer_mode, hours_left, minutes_left, seconds_left,
                    times_up, sound, output ready);
endinterface

interface cth_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cth_pkg::DUR_W-1:0]        start_duration_ms;

    modport source (output valid, start_duration_ms, input ready);
    modport sink   (input valid, start_duration_ms, output ready);
endinterface

// ----- rtl/cth_step.sv -----
`timescale 1ns / 1ps

// Next-state and result logic for one tick.
module cth_step (
    input  cth_pkg::mode_t   cur_mode,
    input  cth_pkg::hms_t    remain,
    input  cth_pkg::hms_t    set_dur,
    input  cth_pkg::item_t   item,
    output cth_pkg::mode_t   mode_next,
    output cth_pkg::hms_t    remain_next,
    output cth_pkg::hms_t    set_next,
    output cth_pkg::result_t result
);

    logic                 press;
    logic                 held;
    logic                 adj_hit;
    cth_pkg::hms_t        adj_time;
    cth_pkg::hms_t        remain_a;
    cth_pkg::hms_t        remain_b;
    cth_pkg::hms_t        sub_time;
    cth_pkg::mode_t       mode_b;
    logic [cth_pkg::SOUND_W-1:0] sound_b;
    logic                 zero;

    logic signed [11:0]   d_ms;
    logic signed [8:0]    d_s;
    logic signed [7:0]    d_m;
    logic signed [5:0]    d_h;
    logic                 b0;
    logic [1:0]           b1;
    logic                 b2;

    assign press = (item.button == cth_pkg::BTN_PRESS);
    assign held  = (item.button == cth_pkg::BTN_HOLD);

    // Adjust: drop the milliseconds, wrap one unit, clamp to 24:00:00
    always_comb
    begin
        adj_hit  = (cur_mode != cth_pkg::MODE_RUNNING);
        adj_time = remain;
        adj_time.millis = '0;
        case (item.cmd)
            cth_pkg::ADJ_HOUR_UP:
                adj_time.hours = (remain.hours < cth_pkg::HOUR_MAX) ? remain.hours + 5'd1 : '0;
            cth_pkg::ADJ_HOUR_DOWN:
                adj_time.hours = (remain.hours != '0) ? remain.hours - 5'd1 : cth_pkg::HOUR_MAX;
            cth_pkg::ADJ_MIN_UP:
                adj_time.minutes = (remain.minutes < cth_pkg::UNIT_MAX) ?
                                   remain.minutes + 6'd1 : '0;
            cth_pkg::ADJ_MIN_DOWN:
                adj_time.minutes = (remain.minutes != '0) ?
                                   remain.minutes - 6'd1 : cth_pkg::UNIT_MAX;
            cth_pkg::ADJ_SEC_UP:
                adj_time.seconds = (remain.seconds < cth_pkg::UNIT_MAX) ?
                                   remain.seconds + 6'd1 : '0;
            cth_pkg::ADJ_SEC_DOWN:
                adj_time.seconds = (remain.seconds != '0) ?
                                   remain.seconds - 6'd1 : cth_pkg::UNIT_MAX;
            default:
                adj_hit = 1'b0;
        endcase
        if (adj_time.hours == cth_pkg::HOUR_MAX)
        begin
            adj_time.minutes = '0;
            adj_time.seconds = '0;
        end
    end

    assign remain_a = adj_hit ? adj_time : remain;
    assign set_next = adj_hit ? adj_time : set_dur;

    // Mixed-radix subtract of the elapsed time, saturating at zero
    always_comb
    begin
        d_ms = $signed({2'b00, remain_a.millis}) - $signed({2'b00, item.el_ms});
        b0   = d_ms[11];
        sub_time.millis = b0 ? 10'(d_ms + 12'sd1000) : 10'(d_ms);

        d_s = $signed({3'b000, remain_a.seconds}) - $signed({2'b00, item.el_sec})
              - $signed({8'b0, b0});
        if (d_s < -9'sd60)
        begin
            b1 = 2'd2;
            sub_time.seconds = 6'(d_s + 9'sd120);
        end
        else if (d_s < 9'sd0)
        begin
            b1 = 2'd1;
            sub_time.seconds = 6'(d_s + 9'sd60);
        end
        else
        begin
            b1 = 2'd0;
            sub_time.seconds = 6'(d_s);
        end

        d_m = $signed({2'b00, remain_a.minutes}) - $signed({6'b0, b1});
        b2  = d_m[7];
        sub_time.minutes = b2 ? 6'(d_m + 8'sd60) : 6'(d_m);

        d_h = $signed({1'b0, remain_a.hours}) - $signed({5'b0, b2});
        sub_time.hours = 5'(d_h);
        if (d_h[5])
            sub_time = '0;
    end

    // Button handling
    always_comb
    begin
        mode_b   = cur_mode;
        remain_b = remain_a;
        sound_b  = cth_pkg::SOUND_NONE;
        case (cur_mode)
            cth_pkg::MODE_PAUSED:
            begin
                if (press)
                    mode_b = cth_pkg::MODE_RUNNING;
                else if (held)
                begin
                    mode_b  = cth_pkg::MODE_SET_SEC;
                    sound_b = cth_pkg::SOUND_BEEP;
                end
            end
            cth_pkg::MODE_RUNNING:
            begin
                if (press || held)
                begin
                    mode_b  = cth_pkg::MODE_PAUSED;
                    sound_b = cth_pkg::SOUND_BEEP;
                end
                else
                    remain_b = sub_time;
            end
            default:
            begin
                if (press)
                begin
                    sound_b = cth_pkg::SOUND_BEEP;
                    if (cur_mode == cth_pkg::MODE_SET_SEC)
                        mode_b = cth_pkg::MODE_SET_MIN;
                    else if (cur_mode == cth_pkg::MODE_SET_MIN)
                        mode_b = cth_pkg::MODE_SET_HOUR;
                    else
                        mode_b = cth_pkg::MODE_SET_SEC;
                end
                else if (held)
                begin
                    mode_b  = cth_pkg::MODE_PAUSED;
                    sound_b = cth_pkg::SOUND_BEEP;
                end
            end
        endcase
    end

    // Zero check: alarm, pause and reload
    assign zero        = (remain_b == '0);
    assign mode_next   = zero ? cth_pkg::MODE_PAUSED : mode_b;
    assign remain_next = zero ? set_next : remain_b;

    always_comb
    begin
        result.timer_mode = cth_pkg::mode_code(mode_next);
        result.hours      = remain_next.hours;
        result.minutes    = remain_next.minutes;
        result.seconds    = remain_next.seconds;
        result.times_up   = zero;
        result.sound      = zero ? cth_pkg::SOUND_ALARM : sound_b;
    end

endmodule

// ----- rtl/countdown_timer_hms_controller_unit.sv -----
`timescale 1ns / 1ps

// Countdown timer with hours, minutes and seconds, kept to the millisecond.
// item_in carries one tick: a mode-button event, the milliseconds elapsed
// since the previous tick and an optional adjust command. result_out returns
// exactly one item per tick: the mode, the remaining time as hours, minutes
// and seconds, a times-up flag and a buzzer request.
// cfg takes the start duration; it is always ready and saturates the value
// at 24:00:00. Reset brings it back to one minute together with the timer, so
// a written value is held in its register only.
// A tick accepted into the input register moves on to the result register
// once that register is free or being drained. Throughput: one tick per
// cycle while result_out.ready stays high, set by the input register (where the
// elapsed time is split into seconds and milliseconds) and the result
// register, with the whole timer update combinational between them.
// Stall: the result register holds while result_out.ready is low; the input
// register still takes one more tick if empty, then item_in.ready drops until the result is taken.
// Reset (rst_n low, asynchronous): timer paused at 0:01:00, set duration the
// same, both registers empty.
module countdown_timer_hms_controller_unit (
    input  logic          clk,
    input  logic          rst_n,
    cth_item_if.sink      item_in,
    cth_result_if.source  result_out,
    cth_cfg_if.sink       cfg
);

    cth_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    cth_pkg::result_t out_reg;
    logic             out_valid_reg;

    cth_pkg::mode_t   mode_reg;
    cth_pkg::mode_t   mode_next;
    cth_pkg::hms_t    remain_reg;
    cth_pkg::hms_t    remain_next;
    cth_pkg::hms_t    set_reg;
    cth_pkg::hms_t    set_next;
    cth_pkg::result_t result_next;

    logic [cth_pkg::DUR_W-1:0] start_duration_reg;

    logic             advance;
    logic             accept;
    cth_pkg::item_t   split_item;
    logic [26:0]      recip_prod;
    logic [16:0]      sec_x1000;

    // Advance the tick when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !in_valid_reg || advance;
    assign accept        = item_in.valid && item_in.ready;

    // Split elapsed milliseconds into whole seconds and the rest
    always_comb
    begin
        recip_prod = 27'(item_in.elapsed_ms[15:3]) * 27'(cth_pkg::SEC_RECIP);
        split_item.button = item_in.button_event;
        split_item.cmd    = item_in.mode;
        split_item.el_sec = recip_prod[cth_pkg::SEC_SHIFT +: cth_pkg::SEC_Q_W];
        sec_x1000         = 17'(split_item.el_sec) * cth_pkg::MS_PER_SEC;
        split_item.el_ms  = 10'(17'(item_in.elapsed_ms) - sec_x1000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Input payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= split_item;
    end

    cth_step u_step (
        .cur_mode    (mode_reg),
        .remain      (remain_reg),
        .set_dur     (set_reg),
        .item        (in_item_reg),
        .mode_next   (mode_next),
        .remain_next (remain_next),
        .set_next    (set_next),
        .result      (result_next)
    );

    // Timer state moves once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= cth_pkg::MODE_PAUSED;
            remain_reg <= cth_pkg::START_TIME_RST;
            set_reg    <= cth_pkg::START_TIME_RST;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            remain_reg <= remain_next;
            set_reg    <= set_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.timer_mode   = out_reg.timer_mode;
    assign result_out.hours_left   = out_reg.hours;
    assign result_out.minutes_left = out_reg.minutes;
    assign result_out.seconds_left = out_reg.seconds;
    assign result_out.times_up     = out_reg.times_up;
    assign result_out.sound        = out_reg.sound;

    // Start duration register: saturate at 24:00:00
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_duration_reg <= cth_pkg::START_DURATION_RST;
        else if (cfg.valid)
            start_duration_reg <= (cfg.start_duration_ms > cth_pkg::MS_MAX) ?
                                  cth_pkg::MS_MAX : cfg.start_duration_ms;
    end

    // Checks
    a_alarm_pauses: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.times_up |->
            out_reg.sound == cth_pkg::SOUND_ALARM &&
            out_reg.timer_mode == cth_pkg::CODE_PAUSED)
        else $error("times-up result without alarm or pause");

    a_time_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg.hours == cth_pkg::HOUR_MAX |->
            remain_reg.minutes == '0 && remain_reg.seconds == '0 &&
            remain_reg.millis == '0)
        else $error("remaining time above 24:00:00");

    a_set_held_running: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == cth_pkg::MODE_RUNNING |=> $stable(set_reg))
        else $error("set duration changed while running");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && !$stable(remain_reg) || out_valid_reg)
        else $error("tick advanced without a result");

    a_start_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        start_duration_reg <= cth_pkg::MS_MAX)
        else $error("start duration above 24:00:00");

endmodule

// ----- test/cth_timer_check.sv -----
`timescale 1ns / 1ps

module cth_timer_check (
    input  logic  clk,
    input  logic  rst_n,
    cth_item_if   tick,
    cth_result_if readout,
    cth_cfg_if    duration,
    output int    fail_count,
    output int    pending
);
    import cth_pkg::*;

    localparam int unsigned MS_HOUR = 3600000;
    localparam int unsigned MS_MIN  = 60000;
    localparam int unsigned MS_SEC  = 1000;

    logic [CODE_W-1:0] mode_now;
    logic [DUR_W-1:0]  left_ms;
    logic [DUR_W-1:0]  set_ms;
    // Written duration; the timer never loads it, and a reset sets it back to one minute
    logic [DUR_W-1:0]  start_cfg_ms;
    result_t           awaited_readouts[$];

    task automatic flag_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Advance the timer by one tick and return the readout it produces
    function automatic result_t advance_countdown(input logic [BTN_W-1:0] btn,
                                                  input logic [ELAPSED_W-1:0] el,
                                                  input logic [CMD_W-1:0] cmd);
        result_t            r;
        int unsigned        whole;
        int unsigned        h;
        int unsigned        m;
        int unsigned        s;
        int unsigned        total;
        logic               touched;
        logic [SOUND_W-1:0] buzz;
        buzz = SOUND_NONE;
        if (mode_now != CODE_RUNNING)
        begin
            whole   = (left_ms / MS_SEC) * MS_SEC;
            h       = whole / MS_HOUR;
            m       = (whole % MS_HOUR) / MS_MIN;
            s       = (whole % MS_MIN) / MS_SEC;
            touched = 1'b1;
            case (cmd)
                ADJ_HOUR_UP:   h = (h < HOUR_MAX) ? h + 1 : 0;
                ADJ_HOUR_DOWN: h = (h > 0) ? h - 1 : HOUR_MAX;
                ADJ_MIN_UP:    m = (m < UNIT_MAX) ? m + 1 : 0;
                ADJ_MIN_DOWN:  m = (m > 0) ? m - 1 : UNIT_MAX;
                ADJ_SEC_UP:    s = (s < UNIT_MAX) ? s + 1 : 0;
                ADJ_SEC_DOWN:  s = (s > 0) ? s - 1 : UNIT_MAX;
                default:       touched = 1'b0;
            endcase
            if (touched)
            begin
                total = h * MS_HOUR + m * MS_MIN + s * MS_SEC;
                if (total > MS_MAX)
                begin
                    total = MS_MAX;
                end
                left_ms = DUR_W'(total);
                set_ms  = DUR_W'(total);
            end
        end

        case (mode_now)
            CODE_PAUSED:
            begin
                if (btn == BTN_PRESS)
                begin
                    mode_now = CODE_RUNNING;
                end
                else if (btn == BTN_HOLD)
                begin
                    mode_now = CODE_SET_SEC;
                    buzz     = SOUND_BEEP;
                end
            end
            CODE_RUNNING:
            begin
                if (btn == BTN_PRESS || btn == BTN_HOLD)
                begin
                    mode_now = CODE_PAUSED;
                    buzz     = SOUND_BEEP;
                end
                else
                begin
                    left_ms = (DUR_W'(el) >= left_ms) ? '0 : left_ms - DUR_W'(el);
                end
            end
            default:
            begin
                if (btn == BTN_PRESS)
                begin
                    mode_now = (mode_now == CODE_SET_SEC) ? CODE_SET_MIN :
                               (mode_now == CODE_SET_MIN) ? CODE_SET_HOUR : CODE_SET_SEC;
                    buzz     = SOUND_BEEP;
                end
                else if (btn == BTN_HOLD)
                begin
                    mode_now = CODE_PAUSED;
                    buzz     = SOUND_BEEP;
                end
            end
        endcase

        // Expiry wins over any beep and reloads the set duration
        r.times_up = (left_ms == '0);
        if (r.times_up)
        begin
            buzz     = SOUND_ALARM;
            mode_now = CODE_PAUSED;
            left_ms  = set_ms;
        end

        r.timer_mode = mode_now;
        r.hours      = HOUR_W'(left_ms / MS_HOUR);
        r.minutes    = UNIT_W'((left_ms % MS_HOUR) / MS_MIN);
        r.seconds    = UNIT_W'((left_ms % MS_MIN) / MS_SEC);
        r.sound      = buzz;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cfg_ms = START_DURATION_RST;
            mode_now     = CODE_PAUSED;
            left_ms      = start_cfg_ms;
            set_ms       = start_cfg_ms;
            awaited_readouts.delete();
            fail_count   = 0;
            pending     <= 0;
        end
        else
        begin
            if (duration.valid && duration.ready)
            begin
                start_cfg_ms = (duration.start_duration_ms > MS_MAX) ?
                               MS_MAX : duration.start_duration_ms;
            end
            // Retire before predicting: a readout never belongs to this edge's tick
            if (readout.valid && readout.ready)
            begin
                if (awaited_readouts.size() == 0)
                begin
                    flag_error("readout arrived with no tick outstanding");
                end
                else
                begin
                    result_t want;
                    want = awaited_readouts.pop_front();
                    compare_field("timer_mode", readout.timer_mode, want.timer_mode);
                    compare_field("hours_left", readout.hours_left, want.hours);
                    compare_field("minutes_left", readout.minutes_left, want.minutes);
                    compare_field("seconds_left", readout.seconds_left, want.seconds);
                    compare_field("times_up", readout.times_up, want.times_up);
                    compare_field("sound", readout.sound, want.sound);
                end
            end
            if (tick.valid && tick.ready)
            begin
                awaited_readouts.push_back(
                    advance_countdown(tick.button_event, tick.elapsed_ms, tick.mode));
            end
            pending <= awaited_readouts.size();
        end
    end

endmodule

// ----- test/countdown_timer_hms_controller_unit_test.sv -----
`timescale 1ns / 1ps

module countdown_timer_hms_controller_unit_test;
    import cth_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [BTN_W-1:0] BTN_NONE   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_UNUSED = 2'd3;
    localparam logic [CMD_W-1:0] ADJ_NONE   = 3'd0;
    localparam logic [CMD_W-1:0] ADJ_UNUSED = 3'd7;

    // Room for a result to clear the two register stages
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 300000;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   ticks_sent;
    int   cycles = 0;
    int   send_idle_pct;
    int   recv_stall_pct;

    cth_item_if   tick_ch();
    cth_result_if readout_ch();
    cth_cfg_if    duration_ch();

    countdown_timer_hms_controller_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (tick_ch),
        .result_out (readout_ch),
        .cfg        (duration_ch)
    );

    cth_timer_check i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick_ch),
        .readout    (readout_ch),
        .duration   (duration_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // Stall the readout side at the rate of the current phase
    always @(posedge clk)
    begin
        readout_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("countdown_timer_hms_controller_unit_test failed");
            $finish;
        end
    end

    // Offer one tick, idling first at the phase rate, and hold it until taken.
    // Leave valid high on return so back-to-back ticks need no second write.
    task automatic send_tick(input logic [BTN_W-1:0] btn, input logic [ELAPSED_W-1:0] el,
                             input logic [CMD_W-1:0] cmd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.button_event <= btn;
        tick_ch.elapsed_ms   <= el;
        tick_ch.mode         <= cmd;
        @(posedge clk);
        while (!tick_ch.ready)
        begin
            @(posedge clk);
        end
        ticks_sent++;
    endtask

    // Drop valid and hold off until every readout has come back and the
    // pipeline has had time to empty.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the start duration; the block must be idle here
    task automatic write_duration(input logic [DUR_W-1:0] value);
        duration_ch.valid             <= 1'b1;
        duration_ch.start_duration_ms <= value;
        @(posedge clk);
        while (!duration_ch.ready)
        begin
            @(posedge clk);
        end
        duration_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One well-formed use: set a duration, start, let it run, maybe stop it
    task automatic play_countdown();
        int unsigned n_adj;
        int unsigned n_run;
        logic [BTN_W-1:0]     btn;
        logic [ELAPSED_W-1:0] el;
        logic [CMD_W-1:0]     cmd;
        n_adj = $urandom_range(0, 5);
        n_run = $urandom_range(1, 25);
        repeat (n_adj)
        begin
            send_tick(BTN_NONE, ELAPSED_W'($urandom_range(0, 65535)),
                      CMD_W'($urandom_range(ADJ_HOUR_UP, ADJ_SEC_DOWN)));
        end
        send_tick(BTN_PRESS, ELAPSED_W'($urandom_range(0, 65535)), ADJ_NONE);
        repeat (n_run)
        begin
            // Mix short ticks with long ones so runs both linger and expire
            el  = $urandom_range(0, 1) ? ELAPSED_W'($urandom_range(0, 65535)) :
                                         ELAPSED_W'($urandom_range(0, 3000));
            cmd = ($urandom_range(99) < 20) ? CMD_W'($urandom_range(0, 7)) : ADJ_NONE;
            btn = ($urandom_range(99) < 6) ? BTN_W'($urandom_range(1, 3)) : BTN_NONE;
            send_tick(btn, el, cmd);
        end
        if ($urandom_range(1))
        begin
            send_tick($urandom_range(1) ? BTN_PRESS : BTN_HOLD,
                      ELAPSED_W'($urandom_range(0, 65535)), ADJ_NONE);
        end
    endtask

    // Advance random traffic until the running tick count reaches target
    task automatic random_phase(input int target);
        while (ticks_sent < target)
        begin
            if ($urandom_range(99) < 75)
            begin
                play_countdown();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_tick(BTN_W'($urandom_range(0, 3)), ELAPSED_W'($urandom()),
                              CMD_W'($urandom_range(0, 7)));
                end
            end
            // Now and then hold off until all readouts are back
            if ($urandom_range(99) < 3)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n                         = 1'b0;
        ticks_sent                    = 0;
        send_idle_pct                 = 10;
        recv_stall_pct                = 52;
        tick_ch.valid                 = 1'b0;
        tick_ch.button_event          = BTN_NONE;
        tick_ch.elapsed_ms            = '0;
        tick_ch.mode                  = ADJ_NONE;
        duration_ch.valid             = 1'b0;
        duration_ch.start_duration_ms = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Top of the range; held in the register only, the timer keeps 0:01:00
        write_duration(MS_MAX);

        // Directed: paused ignores elapsed time, even the largest
        send_tick(BTN_NONE, 16'hFFFF, ADJ_NONE);
        // Hour down from zero wraps to 24 and clamps to 24:00:00
        send_tick(BTN_NONE, '0, ADJ_HOUR_DOWN);
        // Hour up from 24 wraps to zero; alarm beats the beep of the hold
        send_tick(BTN_HOLD, '0, ADJ_HOUR_UP);
        // Set duration zero: the alarm fires on the start tick too
        send_tick(BTN_PRESS, '0, ADJ_NONE);
        // Seconds and minutes wrap both ways
        send_tick(BTN_NONE, '0, ADJ_SEC_DOWN);
        send_tick(BTN_NONE, '0, ADJ_MIN_DOWN);
        send_tick(BTN_NONE, '0, ADJ_MIN_UP);
        send_tick(BTN_NONE, '0, ADJ_SEC_UP);
        send_tick(BTN_NONE, '0, ADJ_SEC_UP);
        // Start tick subtracts nothing
        send_tick(BTN_PRESS, 16'hFFFF, ADJ_NONE);
        // Adjust ignored while running
        send_tick(BTN_NONE, 16'd500, ADJ_HOUR_UP);
        // Button code three counts as no event
        send_tick(BTN_UNUSED, 16'd499, ADJ_NONE);
        // Subtract saturates at zero, alarm, reload
        send_tick(BTN_NONE, 16'hFFFF, ADJ_NONE);
        // Hold enters setting; adjust code seven does nothing
        send_tick(BTN_HOLD, '0, ADJ_UNUSED);
        // Cycle seconds, minutes, hours, seconds, then hold back to paused
        send_tick(BTN_PRESS, '0, ADJ_NONE);
        send_tick(BTN_PRESS, '0, ADJ_NONE);
        send_tick(BTN_PRESS, '0, ADJ_NONE);
        send_tick(BTN_HOLD, '0, ADJ_NONE);
        // Run part of a second, hold to pause, then drop the milliseconds
        send_tick(BTN_PRESS, '0, ADJ_NONE);
        send_tick(BTN_NONE, 16'd300, ADJ_NONE);
        send_tick(BTN_HOLD, '0, ADJ_NONE);
        send_tick(BTN_NONE, '0, ADJ_SEC_UP);
        // Press while running pauses with a beep
        send_tick(BTN_PRESS, '0, ADJ_NONE);
        send_tick(BTN_PRESS, '0, ADJ_NONE);
        send_tick(BTN_NONE, '0, ADJ_HOUR_UP);

        random_phase(650);

        // Sender stalls more than the receiver in this phase
        wait_drained();
        write_duration('0);
        send_idle_pct  = 52;
        recv_stall_pct = 10;
        random_phase(1300);

        // Above the range saturates; then any value; then no idling at all
        wait_drained();
        write_duration({DUR_W{1'b1}});
        write_duration(DUR_W'($urandom_range(0, MS_MAX)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(1925);

        wait_drained();
        write_duration(START_DURATION_RST);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("countdown_timer_hms_controller_unit_test passed");
        end
        else
        begin
            $display("countdown_timer_hms_controller_unit_test failed");
        end
        $finish;
    end

endmodule
